/* src/bgc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bgc_pkg;

  localparam int TICK_BITS = 8;
  localparam int CFG_W     = 8;
  localparam int CMP_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [CFG_W-1:0]     cfg_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_PRESS   = 3'd1,
    MODE_CLICK   = 3'd2,
    MODE_HOLD    = 3'd3,
    MODE_RELEASE = 3'd4
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LIMIT          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_GAP           = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_REPEAT_INTERVAL = 2'd2;

  localparam cfg_t PRESS_LIMIT_RST          = 8'd50;
  localparam cfg_t SETTLE_GAP_RST           = 8'd20;
  localparam cfg_t HOLD_REPEAT_INTERVAL_RST = 8'd10;

endpackage

`default_nettype wire

/* src/button_gesture_classifier_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Registered result: out_tdata holds it from the cycle after its word is accepted.
// Throughput: one word per cycle; the single output register takes a new result
// in the same cycle that the held one is taken, so in_tready drops only on a stall.
// Reset: synchronous, active low; mode idle, tick and last-event counters zero,
// registers back to press limit 50, settle gap 20, hold repeat interval 10.
module button_gesture_classifier_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [0] button_down, [7:1] zero
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [0] event_valid, [3:1] event_mode,
                                      // [6:4] current_mode, [7] zero
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bgc_pkg::CFG_W-1:0]     cfg_data
);

  bgc_pkg::mode_t mode_r, mode_nxt;
  bgc_pkg::tick_t tick_r, tick_nxt;
  bgc_pkg::tick_t last_r, last_nxt;
  bgc_pkg::tick_t elapsed;
  bgc_pkg::cfg_t  press_limit_r;
  bgc_pkg::cfg_t  settle_gap_r;
  bgc_pkg::cfg_t  hold_repeat_interval_r;

  logic           fire;
  bgc_pkg::mode_t fire_mode;
  logic           down;
  logic           in_fire;
  logic           out_valid_r;
  logic [7:0]     out_data_r, out_data_nxt;
  logic           hit_threshold, hit_gap, hit_repeat;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign down       = in_tdata[0];

  assign tick_nxt = bgc_pkg::tick_t'(tick_r + 1'b1);
  assign elapsed  = bgc_pkg::tick_t'(tick_nxt - last_r);

  assign hit_threshold = bgc_pkg::CMP_W'(elapsed) == bgc_pkg::CMP_W'(press_limit_r);
  assign hit_gap       = bgc_pkg::CMP_W'(elapsed) == bgc_pkg::CMP_W'(settle_gap_r);
  assign hit_repeat    = bgc_pkg::CMP_W'(elapsed) == bgc_pkg::CMP_W'(hold_repeat_interval_r);

  // next mode and event
  always_comb begin
    fire      = 1'b0;
    fire_mode = bgc_pkg::MODE_IDLE;
    unique case (mode_r)
      bgc_pkg::MODE_PRESS: begin
        if (!down) begin
          fire      = 1'b1;
          fire_mode = bgc_pkg::MODE_CLICK;
        end else if (hit_threshold) begin
          fire      = 1'b1;
          fire_mode = bgc_pkg::MODE_HOLD;
        end
      end
      bgc_pkg::MODE_CLICK, bgc_pkg::MODE_RELEASE: begin
        if (hit_gap) begin
          fire      = 1'b1;
          fire_mode = bgc_pkg::MODE_IDLE;
        end
      end
      bgc_pkg::MODE_HOLD: begin
        if (!down) begin
          fire      = 1'b1;
          fire_mode = bgc_pkg::MODE_RELEASE;
        end else if (hit_repeat) begin
          fire      = 1'b1;
          fire_mode = bgc_pkg::MODE_HOLD;
        end
      end
      default: begin
        if (down) begin
          fire      = 1'b1;
          fire_mode = bgc_pkg::MODE_PRESS;
        end
      end
    endcase
    if (fire) begin
      mode_nxt = fire_mode;
      last_nxt = tick_nxt;
    end else if (mode_r == bgc_pkg::MODE_PRESS || mode_r == bgc_pkg::MODE_CLICK ||
                 mode_r == bgc_pkg::MODE_HOLD || mode_r == bgc_pkg::MODE_RELEASE) begin
      mode_nxt = mode_r;
      last_nxt = last_r;
    end else begin
      mode_nxt = bgc_pkg::MODE_IDLE;
      last_nxt = last_r;
    end
  end

  // result word
  always_comb begin
    out_data_nxt      = '0;
    out_data_nxt[0]   = fire;
    out_data_nxt[3:1] = fire_mode;
    out_data_nxt[6:4] = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= bgc_pkg::MODE_IDLE;
      tick_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r      <= mode_nxt;
        tick_r      <= tick_nxt;
        last_r      <= last_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_limit_r          <= bgc_pkg::PRESS_LIMIT_RST;
      settle_gap_r           <= bgc_pkg::SETTLE_GAP_RST;
      hold_repeat_interval_r <= bgc_pkg::HOLD_REPEAT_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bgc_pkg::REG_PRESS_LIMIT:          press_limit_r          <= cfg_data;
        bgc_pkg::REG_SETTLE_GAP:           settle_gap_r           <= cfg_data;
        bgc_pkg::REG_HOLD_REPEAT_INTERVAL: hold_repeat_interval_r <= cfg_data;
        default: ;
      endcase
    end
  end

  a_quiet_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(mode_r) && $stable(tick_r) && $stable(last_r))
    else $error("state moved without an accepted word");

  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> tick_r == bgc_pkg::tick_t'($past(tick_r) + 1'b1))
    else $error("tick counter did not advance by one");

  a_change_fires: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && mode_nxt != mode_r |=> out_data_r[0])
    else $error("mode change without event");

  a_event_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[0] |-> out_data_r[3:1] == out_data_r[6:4])
    else $error("event mode differs from current mode");

  a_no_event_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[0] |-> out_data_r[3:1] == bgc_pkg::MODE_IDLE)
    else $error("event mode set without event");

endmodule

`default_nettype wire
